// File: hdl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared constants and types for the TLB page translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Address split
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned PAGE_SIZE   = 256;
  localparam int unsigned PAGE_COUNT  = 256;
  localparam int unsigned OFFSET_W    = $clog2(PAGE_SIZE);
  localparam int unsigned PAGE_W      = $clog2(PAGE_COUNT);

  // Frames: 8-bit frame number, at most 256 frames
  localparam int unsigned FRAME_W     = 8;
  localparam int unsigned FCOUNT_W    = 9;
  localparam logic [FCOUNT_W-1:0] FRAME_LIMIT   = 9'd256;
  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET  = 9'd256;

  // Result word layout
  localparam int unsigned OUT_CNT_W   = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 3;

  // Defaults for top-level parameters
  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch incoming word, start page-map read
    logic commit;   // resolve lookup, update state, load result
  } tlbpt_cmd_t;

endpackage

// File: hdl/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Two-state sequencer: accept a word, then resolve it into the result register.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output tlbpt_pkg::tlbpt_cmd_t cmd_o
);
  import tlbpt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   slot_free;

  // Result register can take a new word
  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;

  assign cmd_o.capture = (state_q == ST_IDLE) && s_axis_tvalid;
  assign cmd_o.commit  = (state_q == ST_LOOKUP) && slot_free;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (m_axis_tready) m_valid_q <= 1'b0;
          if (s_axis_tvalid) state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/tlbpt_datapath.sv
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB array, page map, frame allocator, counters and result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS  = tlbpt_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tlbpt_pkg::tlbpt_cmd_t              cmd_i,
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                               cfg_valid_i,
  input  logic [tlbpt_pkg::FCOUNT_W-1:0]     cfg_data_i,
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [tlbpt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import tlbpt_pkg::*;

  localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TLB_ENTRIES - 1);

  // Captured request
  logic [PAGE_W-1:0]   page_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [FRAME_W-1:0]  map_rd_q;

  // TLB
  logic [PAGE_W-1:0]      tlb_page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [IDX_W-1:0]       victim_q;

  // Page map: frame memory plus mapped flags
  logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] mapped_q;

  logic [FCOUNT_W-1:0]   frames_used_q;
  logic [FCOUNT_W-1:0]   frame_count_q;
  logic [COUNT_BITS-1:0] hit_total_q;
  logic [COUNT_BITS-1:0] fault_total_q;

  // Result register
  logic [ADDR_W-1:0]    pa_q;
  logic                 hit_flag_q;
  logic                 fault_flag_q;
  logic                 exh_flag_q;
  logic [OUT_CNT_W-1:0] hits_out_q;
  logic [OUT_CNT_W-1:0] faults_out_q;

  // Lookup results
  logic                  hit;
  logic [FRAME_W-1:0]    hit_frame;
  logic                  mapped;
  logic                  fault;
  logic                  can_alloc;
  logic                  exhausted;
  logic                  fill;
  logic [FRAME_W-1:0]    frame;
  logic [FCOUNT_W-1:0]   limit;
  logic [COUNT_BITS-1:0] hit_total_d;
  logic [COUNT_BITS-1:0] fault_total_d;
  logic [PAGE_W-1:0]     in_page;

  assign in_page = s_axis_tdata[OFFSET_W +: PAGE_W];

  // First valid matching TLB entry wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_q[i];
      end
    end
  end

  // Miss handling and allocation
  always_comb begin
    limit     = (frame_count_q > FRAME_LIMIT) ? FRAME_LIMIT : frame_count_q;
    mapped    = mapped_q[page_q];
    fault     = !hit && !mapped;
    can_alloc = frames_used_q < limit;
    exhausted = fault && !can_alloc;
    fill      = !hit && (mapped || can_alloc);
    priority if (hit) frame = hit_frame;
    else if (mapped)  frame = map_rd_q;
    else              frame = frames_used_q[FRAME_W-1:0];
    hit_total_d   = hit_total_q;
    fault_total_d = fault_total_q;
    if (hit && (hit_total_q != '1))     hit_total_d   = hit_total_q + 1'b1;
    if (fault && (fault_total_q != '1)) fault_total_d = fault_total_q + 1'b1;
  end

  // Capture and page-map read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q   <= in_page;
      offset_q <= s_axis_tdata[OFFSET_W-1:0];
      map_rd_q <= frame_mem[in_page];
    end
  end

  // Page-map write on allocation
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fault && can_alloc) begin
      frame_mem[page_q] <= frame;
    end
  end

  // TLB payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fill) begin
      tlb_page_q[victim_q]  <= page_q;
      tlb_frame_q[victim_q] <= frame;
    end
  end

  // Control state: valid bits, victim, allocator, counters, config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q   <= '0;
      victim_q      <= '0;
      mapped_q      <= '0;
      frames_used_q <= '0;
      hit_total_q   <= '0;
      fault_total_q <= '0;
      frame_count_q <= FCOUNT_RESET;
    end else begin
      if (cfg_valid_i) frame_count_q <= cfg_data_i;
      if (cmd_i.commit) begin
        hit_total_q   <= hit_total_d;
        fault_total_q <= fault_total_d;
        if (fill) begin
          tlb_valid_q[victim_q] <= 1'b1;
          victim_q <= (victim_q == IDX_LAST) ? '0 : victim_q + 1'b1;
        end
        if (fault && can_alloc) begin
          mapped_q[page_q] <= 1'b1;
          frames_used_q    <= frames_used_q + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pa_q         <= exhausted ? '0 : ADDR_W'({frame, offset_q});
      hit_flag_q   <= hit;
      fault_flag_q <= fault;
      exh_flag_q   <= exhausted;
      hits_out_q   <= OUT_CNT_W'(hit_total_d);
      faults_out_q <= OUT_CNT_W'(fault_total_d);
    end
  end

  assign m_axis_tdata = {faults_out_q, hits_out_q, pa_q};
  assign m_axis_tuser = {exh_flag_q, fault_flag_q, hit_flag_q};

endmodule

// File: hdl/tlb_page_table_translator_core.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_core
// TLB with FIFO replacement backed by a demand-paged page map.
// ----------------------------------------------------------------------------
// Sequence: ST_IDLE accepts a word (capture + page-map read); ST_LOOKUP then
//   does the TLB compare and state writeback into the result register, waiting
//   while the result register is stalled. No new word is taken until ST_IDLE.
// Reset: async active low; TLB and page map empty, counters zero,
//   frame_count 256. No clearing pass.
module tlb_page_table_translator_core #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS  = tlbpt_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: logical_address[15:0]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tlbpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tdata: physical_address[15:0], hits_so_far[31:16], faults_so_far[47:32]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: tlb_hit[0], page_fault[1], frames_exhausted[2]
  output logic [tlbpt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  // frame_count register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlbpt_pkg::FCOUNT_W-1:0]     cfg_data_i
);
  import tlbpt_pkg::*;

  tlbpt_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  tlbpt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .s_axis_tdata (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TLB page translator. Drives logical addresses
// over the input stream, predicts every translation (TLB lookup, FIFO refill,
// demand paging, frame exhaustion, saturating counters) and compares each
// result word field by field. Covers frame_count extremes and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import tlbpt_pkg::*;

  localparam int unsigned TLB_N       = TLB_ENTRIES_DEF;
  localparam int unsigned CNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // One expected translation
  typedef struct packed {
    logic [15:0] phys;
    logic        hit;
    logic        fault;
    logic        exhausted;
    logic [15:0] hits;
    logic [15:0] faults;
  } xlat_t;

  // Clock, reset and DUT ports
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [FCOUNT_W-1:0]    cfg_data_i    = '0;

  // Predicted block state
  logic [7:0]          tlb_pg   [TLB_N];
  logic [7:0]          tlb_fr   [TLB_N];
  bit                  tlb_ok   [TLB_N];
  int unsigned         victim;
  logic [7:0]          pmap_frame [256];
  bit                  pmap_ok    [256];
  int unsigned         frames_used;
  int unsigned         hit_cnt;
  int unsigned         fault_cnt;
  logic [FCOUNT_W-1:0] frame_limit_reg;

  // Bench bookkeeping
  xlat_t       pending_xlat[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int          burst_left = 0;
  bit          tx_gaps    = 1'b0;
  rx_mode_e    rx_mode    = RX_ALWAYS;
  int          hold_left  = 0;
  int unsigned rx_tick    = 0;

  tlb_page_table_translator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_axis_tready <= ((rx_tick % 7) < 4);
        default:    m_axis_tready <= 1'b1;
      endcase
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // Result checker: each accepted word against the oldest translation
  always @(posedge clk_i) begin
    xlat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_xlat.size() == 0) begin
        mismatches++;
        $error("result word with no translation pending");
      end else begin
        want = pending_xlat.pop_front();
        check_field("physical_address", want.phys,      m_axis_tdata[15:0]);
        check_field("hits_so_far",      want.hits,      m_axis_tdata[31:16]);
        check_field("faults_so_far",    want.faults,    m_axis_tdata[47:32]);
        check_field("tlb_hit",          want.hit,       m_axis_tuser[0]);
        check_field("page_fault",       want.fault,     m_axis_tuser[1]);
        check_field("frames_exhausted", want.exhausted, m_axis_tuser[2]);
      end
    end
  end

  function automatic void clear_model();
    for (int i = 0; i < TLB_N; i++) begin
      tlb_pg[i] = '0;
      tlb_fr[i] = '0;
      tlb_ok[i] = 1'b0;
    end
    for (int i = 0; i < 256; i++) begin
      pmap_frame[i] = '0;
      pmap_ok[i]    = 1'b0;
    end
    victim          = 0;
    frames_used     = 0;
    hit_cnt         = 0;
    fault_cnt       = 0;
    frame_limit_reg = FCOUNT_RESET;
  endfunction

  // Load a TLB slot at the FIFO pointer
  function automatic void tlb_load(input logic [7:0] page, input logic [7:0] frame);
    tlb_pg[victim] = page;
    tlb_fr[victim] = frame;
    tlb_ok[victim] = 1'b1;
    victim = (victim + 1) % TLB_N;
  endfunction

  // Translation predictor; updates TLB, page map and counters
  function automatic xlat_t translate_addr(input logic [15:0] addr);
    logic [7:0]  page;
    logic [7:0]  offset;
    logic [7:0]  frame;
    int unsigned lim;
    bit          hit;
    xlat_t       r;
    page   = addr[15:8];
    offset = addr[7:0];
    frame  = '0;
    hit    = 1'b0;
    r      = '0;
    lim    = (frame_limit_reg < FRAME_LIMIT) ? frame_limit_reg : FRAME_LIMIT;
    // lowest matching slot wins
    for (int i = 0; i < TLB_N; i++) begin
      if (!hit && tlb_ok[i] && tlb_pg[i] == page) begin
        hit   = 1'b1;
        frame = tlb_fr[i];
      end
    end
    if (hit) begin
      if (hit_cnt < CNT_MAX) hit_cnt++;
    end else if (pmap_ok[page]) begin
      frame = pmap_frame[page];
      tlb_load(page, frame);
    end else begin
      r.fault = 1'b1;
      if (fault_cnt < CNT_MAX) fault_cnt++;
      if (frames_used < lim) begin
        frame = frames_used[7:0];
        frames_used++;
        pmap_frame[page] = frame;
        pmap_ok[page]    = 1'b1;
        tlb_load(page, frame);
      end else begin
        r.exhausted = 1'b1;
      end
    end
    r.hit    = hit;
    r.phys   = r.exhausted ? 16'h0000 : {frame, offset};
    r.hits   = hit_cnt[OUT_CNT_W-1:0];
    r.faults = fault_cnt[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] pick_page();
    return 8'($urandom);
  endfunction

  // Send one address word; bursts with random gaps when enabled
  task automatic send_addr(input logic [15:0] addr);
    if (tx_gaps) begin
      if (burst_left <= 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_xlat.push_back(translate_addr(addr));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [FCOUNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    frame_limit_reg = value;
  endtask

  // Address extremes, hits, TLB wrap and refill of an evicted mapped page
  task automatic test_directed_map();
    tx_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    send_addr(16'h0000);
    send_addr(16'h00FF);
    send_addr(16'hFFFF);
    send_addr(16'hFF00);
    send_addr(16'h1234);
    // 14 new pages: FIFO pointer wraps and evicts page 0x00
    for (int p = 'h20; p < 'h2E; p++) send_addr({p[7:0], 8'h5A});
    send_addr(16'h00AB);
    send_addr(16'h00AB);
  endtask

  // Exhaustion, frame count zero and frame count below frames in use
  task automatic test_frame_limits();
    drain();
    write_frame_count(FCOUNT_W'(frames_used + 1));
    send_addr(16'h4001);
    send_addr(16'h41FE);
    send_addr(16'h4180);
    send_addr(16'h4077);
    drain();
    write_frame_count('0);
    send_addr(16'h4233);
    send_addr(16'h0011);
    send_addr(16'h12EE);
    drain();
    write_frame_count(FCOUNT_W'(1));
    send_addr(16'h4399);
    send_addr(16'h2D00);
  endtask

  // Working-set traffic with random content plus some noise
  task automatic run_random(input int n_items);
    logic [7:0]  work_set[$];
    logic [15:0] addr;
    int          seg_left;
    seg_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        work_set.delete();
        repeat ($urandom_range(2, 24)) work_set.push_back(pick_page());
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_mode = rx_mode_e'($urandom_range(0, 2));
      end
      seg_left--;
      if ($urandom_range(0, 9) == 0)
        addr = {pick_page(), 8'($urandom)};
      else
        addr = {work_set[$urandom_range(0, work_set.size() - 1)], 8'($urandom)};
      send_addr(addr);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned mid_limit;
    drain();
    write_frame_count('1);
    run_random(170);
    drain();
    mid_limit = frames_used + $urandom_range(0, 24);
    if (mid_limit > 511) mid_limit = 511;
    write_frame_count(FCOUNT_W'(mid_limit));
    run_random(170);
    drain();
    write_frame_count(FCOUNT_W'(256));
    run_random(170);
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_mode   = RX_ALWAYS;
    hold_left = 120;
    for (int k = 0; k < 24; k++) send_addr({pick_page(), 8'($urandom)});
    drain();
  endtask

  // Map every page; the last allocation takes frame 255
  task automatic test_full_page_sweep();
    drain();
    write_frame_count(FCOUNT_W'(256));
    for (int p = 0; p < 256; p++) send_addr({p[7:0], 8'hFF});
    for (int k = 0; k < 32; k++) send_addr(16'($urandom));
  endtask

  // Test sequence
  initial begin
    clear_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_map();
    test_frame_limits();
    test_random_traffic();
    test_backpressure();
    test_full_page_sweep();
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_xlat.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/tlbpt_pkg.sv
hdl/tlbpt_ctrl.sv
hdl/tlbpt_datapath.sv
hdl/tlb_page_table_translator_core.sv
verif/tb_top.sv
